### src/ulsm_pkg.sv
// ulsm_pkg: shared types and constants for the unaligned load/store merge block
// no dependencies

package ulsm_pkg;

    localparam logic [1:0] REQ_LOAD_LEFT   = 2'd0;
    localparam logic [1:0] REQ_LOAD_RIGHT  = 2'd1;
    localparam logic [1:0] REQ_STORE_LEFT  = 2'd2;
    localparam logic [1:0] REQ_STORE_RIGHT = 2'd3;

    localparam logic [31:0] LEFT_RETAIN_MASK = 32'h00ff_ffff;
    localparam logic [31:0] RIGHT_KEEP_MASK  = 32'hffff_ffff;

    localparam int unsigned WORD_ADDR_W = 30;
    localparam int unsigned LANES       = 4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] byte_address;
        logic [31:0] memory_word;
        logic [31:0] register_value;
    } ulsm_req_t;

    typedef struct packed {
        logic [31:0]            load_result;
        logic [WORD_ADDR_W-1:0] word_address;
        logic [LANES-1:0]       lane_enables;
        logic [31:0]            store_word;
    } ulsm_rsp_t;

endpackage

### src/ulsm_merge.sv
// ulsm_merge: combinational lane offset, load merge and store lane placement
// depends on ulsm_pkg

module ulsm_merge (
    input  ulsm_pkg::ulsm_req_t req,
    input  logic                big_endian_mode,
    output ulsm_pkg::ulsm_rsp_t rsp
);
    import ulsm_pkg::*;

    logic [1:0]  lane_ofs;
    logic [4:0]  shamt;
    logic [4:0]  shamt_inv;
    logic [31:0] mask;
    logic [4:0]  left_lanes;

    // big-endian mirrors the lane order
    assign lane_ofs   = req.byte_address[1:0] ^ {2{big_endian_mode}};
    assign shamt      = {lane_ofs, 3'b000};
    assign shamt_inv  = {~lane_ofs, 3'b000};
    assign left_lanes = (5'd2 << lane_ofs) - 5'd1;

    always_comb
    begin
        rsp              = '0;
        rsp.word_address = req.byte_address[31:2];
        mask             = '0;
        case (req.req_type)
            REQ_LOAD_LEFT:
            begin
                mask            = LEFT_RETAIN_MASK >> shamt;
                rsp.load_result = (req.register_value & mask)
                                | ((req.memory_word << shamt_inv) & ~mask);
            end
            REQ_LOAD_RIGHT:
            begin
                mask            = RIGHT_KEEP_MASK >> shamt;
                rsp.load_result = (req.register_value & ~mask)
                                | ((req.memory_word >> shamt) & mask);
            end
            REQ_STORE_LEFT:
            begin
                rsp.lane_enables = left_lanes[LANES-1:0];
                rsp.store_word   = req.register_value >> shamt_inv;
            end
            default:
            begin
                rsp.lane_enables = 4'hf << lane_ofs;
                rsp.store_word   = req.register_value << shamt;
            end
        endcase
    end

endmodule

### src/unaligned_load_store_merge_core.sv
// unaligned_load_store_merge_core: top level with input and result registers
// depends on ulsm_pkg and ulsm_merge
//
// usage:
//   one word access is accepted at each rising edge where start is high and
//   busy is low; busy is always low, so a new access can enter every cycle
//   req carries the access type, byte address, aligned memory word and the
//   register value
//   the result passes the input and result registers, is driven on rsp by the
//   result register, marked by result_valid for exactly one cycle, and is taken
//   while result_valid is high; sustained throughput is one word per cycle, set
//   by the single merge stage between the two registers
//   the receiver cannot stall: every result must be taken in its cycle
//   cfg_we with cfg_wdata writes big_endian_mode; write it only while no
//   access is in flight
//   reset clears the valid flags and sets little-endian mode; words in flight
//   are dropped

module unaligned_load_store_merge_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ulsm_pkg::ulsm_req_t req,
    output logic                result_valid,
    output ulsm_pkg::ulsm_rsp_t rsp,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);
    import ulsm_pkg::*;

    logic      big_endian_reg;
    logic      in_valid_reg;
    ulsm_req_t in_reg;
    logic      out_valid_reg;
    ulsm_rsp_t out_reg;
    ulsm_rsp_t rsp_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                big_endian_reg <= cfg_wdata;
            end
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= req;
        end
        if (in_valid_reg)
        begin
            out_reg <= rsp_next;
        end
    end

    ulsm_merge u_merge (
        .req             (in_reg),
        .big_endian_mode (big_endian_reg),
        .rsp             (rsp_next)
    );

    assign result_valid = out_valid_reg;
    assign rsp          = out_reg;

endmodule
